/* design/ldp_pkg.sv */
// ----------------------------------------------------------------------------
// ldp_pkg
// Shared types, constants and the per-column coding step of the codec.
// ----------------------------------------------------------------------------
package ldp_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int BLOCK_ROWS  = 8;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CNT_W       = COL_W + 1;
   localparam int ROW_W       = $clog2(BLOCK_ROWS);
   localparam int GRAD_SHIFT  = $clog2(BLOCK_ROWS / 2);
   localparam int OQ_DEPTH    = 3;

   typedef enum logic [1:0] {
      REG_DECODE_MODE    = 2'd0,
      REG_WIDE_SAMPLES   = 2'd1,
      REG_COLUMN_COUNT   = 2'd2,
      REG_LEARNED_BLOCKS = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] grad_sum;
      logic [31:0] coef_cnt;
      logic [15:0] prev_delta;
      logic [15:0] prev_value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             learned;
      logic             first;
   } pos_type;

   typedef struct packed {
      entry_type   st;
      logic [15:0] dout;
   } step_type;

   function automatic step_type ldp_step(entry_type st, logic [15:0] din,
                                         logic [ROW_W-1:0] row, logic learned,
                                         logic dec, logic wide);
      logic [15:0]        m;
      logic [15:0]        x;
      logic [15:0]        pv;
      logic [15:0]        pd;
      logic [15:0]        coef;
      logic [15:0]        a16;
      logic signed [31:0] prod;
      logic [15:0]        pred;
      logic [15:0]        delta;
      logic [15:0]        val;
      logic [15:0]        err;
      logic [15:0]        g;
      logic [15:0]        gsum;
      logic               eneg;
      logic signed [15:0] adj16;
      logic signed [7:0]  adj8;
      step_type           r;
      m    = wide ? 16'hffff : 16'h00ff;
      x    = din & m;
      pv   = st.prev_value & m;
      pd   = st.prev_delta & m;
      coef = wide ? {st.coef_cnt[18:15], 12'h000}
                  : {st.coef_cnt[15], st.coef_cnt[15:5], 4'h0};
      a16  = wide ? pd : {{8{pd[7]}}, pd[7:0]};
      prod = $signed(a16) * $signed(coef);
      if (!learned) begin
         pred = 16'h0000;
      end else if (wide) begin
         pred = {prod[29:16], 2'b00};
      end else begin
         pred = {8'h00, prod[15:8]};
      end
      if (dec) begin
         err   = x;
         delta = (x + pred) & m;
         val   = (delta + pv) & m;
         r.dout = val;
      end else begin
         val   = x;
         delta = (x - pv) & m;
         err   = (delta - pred) & m;
         r.dout = err;
      end
      eneg = wide ? err[15] : err[7];
      if (err == 16'h0000) begin
         g = 16'h0000;
      end else if (eneg) begin
         g = 16'h0000 - pd;
      end else begin
         g = pd;
      end
      r.st            = st;
      r.st.prev_value = val;
      r.st.prev_delta = delta;
      gsum            = st.grad_sum;
      if (learned) begin
         if (row[0]) begin
            gsum          = (gsum + g) & m;
            r.st.grad_sum = gsum;
         end
         if (row == ROW_W'(BLOCK_ROWS - 1)) begin
            if (wide) begin
               adj16 = $signed(gsum);
               adj16 = adj16 >>> GRAD_SHIFT;
               r.st.coef_cnt = st.coef_cnt + {{16{adj16[15]}}, adj16};
            end else begin
               adj8 = $signed(gsum[7:0]);
               adj8 = adj8 >>> GRAD_SHIFT;
               r.st.coef_cnt = {16'h0000, st.coef_cnt[15:0] + {{8{adj8[7]}}, adj8}};
            end
            r.st.grad_sum = 16'h0000;
         end
      end
      return r;
   endfunction

endpackage

/* design/ldp_ram.sv */
// ----------------------------------------------------------------------------
// ldp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ldp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ldp_seq.sv */
// ----------------------------------------------------------------------------
// ldp_seq
// Column, row and block position tracking for each accepted request.
// ----------------------------------------------------------------------------
module ldp_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 first,
   input  logic [6:0]           column_count,
   input  logic [23:0]          learned_blocks,
   output ldp_pkg::pos_type     pos
);

   logic [ldp_pkg::COL_W-1:0] col_ff, col_in, col0, c;
   logic [ldp_pkg::ROW_W-1:0] row_ff, row_in, row0;
   logic [23:0]               bd_ff, bd_in, bd0;
   logic [ldp_pkg::CNT_W-1:0] cols, cnext;
   logic                      learned;

   always_comb begin
      col0 = first ? '0 : col_ff;
      row0 = first ? '0 : row_ff;
      bd0  = first ? '0 : bd_ff;
      if (column_count == 7'd0) begin
         cols = ldp_pkg::CNT_W'(1);
      end else if ({{(ldp_pkg::CNT_W){1'b0}}, column_count} >
                   (ldp_pkg::CNT_W + 7)'(ldp_pkg::MAX_COLUMNS)) begin
         cols = ldp_pkg::CNT_W'(ldp_pkg::MAX_COLUMNS);
      end else begin
         cols = ldp_pkg::CNT_W'(column_count);
      end
      c       = ({1'b0, col0} >= cols) ? '0 : col0;
      learned = bd0 < learned_blocks;
      cnext   = {1'b0, c} + ldp_pkg::CNT_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      bd_in   = bd_ff;
      if (accept) begin
         col_in = cnext[ldp_pkg::COL_W-1:0];
         row_in = row0;
         bd_in  = bd0;
         if (cnext >= cols) begin
            col_in = '0;
            if (row0 == ldp_pkg::ROW_W'(ldp_pkg::BLOCK_ROWS - 1)) begin
               row_in = '0;
               bd_in  = bd0 + {23'd0, learned};
            end else begin
               row_in = row0 + ldp_pkg::ROW_W'(1);
            end
         end
      end
      pos.col     = c;
      pos.row     = row0;
      pos.learned = learned;
      pos.first   = first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         bd_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         bd_ff  <= bd_in;
      end
   end

endmodule

/* design/ldp_outq.sv */
// ----------------------------------------------------------------------------
// ldp_outq
// Small result queue between the datapath and the response channel.
// ----------------------------------------------------------------------------
module ldp_outq (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [15:0] push_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  count
);

   logic [15:0] data_ff [ldp_pkg::OQ_DEPTH];
   logic [1:0]  wr_ff, wr_in, rd_ff, rd_in, count_ff, count_in;
   logic        pop;

   always_comb begin
      pop      = rsp_tvalid && rsp_tready;
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == 2'(ldp_pkg::OQ_DEPTH - 1)) ? 2'd0 : wr_ff + 2'd1;
      end
      if (pop) begin
         rd_in = (rd_ff == 2'(ldp_pkg::OQ_DEPTH - 1)) ? 2'd0 : rd_ff + 2'd1;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ff] <= push_data;
      end
   end

   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = data_ff[rd_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == 2'(ldp_pkg::OQ_DEPTH)))
      else $error("result queue overflow");

endmodule

/* design/learned_delta_predictor_codec_core.sv */
// ----------------------------------------------------------------------------
// learned_delta_predictor_codec_core
// Learned delta predictive codec: per-column state in one RAM, one request
// per clock with a read-modify-write pipeline and write-to-read forwarding.
//
//   channel  dir  handshake            payload
//   req_     in   req_tvalid/tready    tdata = sample_in, tuser = first_item
//   rsp_     out  rsp_tvalid/tready    tdata = sample_out
//   csr_     in   csr_valid/ready      csr_index, csr_wdata
//
// One request per cycle while req_tready is high; a result passes the state
// RAM read and the coding stage, then the result queue, before it reaches rsp_.
// Reset clears position, valid bits and queue; no clearing pass is needed.
// A three-entry result queue absorbs rsp_ stalls; req_tready drops only when
// the queue plus the request in flight would fill it.
// ----------------------------------------------------------------------------
module learned_delta_predictor_codec_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   input  logic        req_tuser,   // [0] first_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic                  dec_ff, wide_ff;
   logic [6:0]            cols_ff;
   logic [23:0]           lblk_ff;
   logic                  accept;
   ldp_pkg::pos_type      pos;
   logic                  s1_v_ff;
   ldp_pkg::pos_type      s1_pos_ff;
   logic [15:0]           s1_din_ff;
   logic                  s1_vld_ff, s1_fwd_ff;
   ldp_pkg::entry_type    fwd_ff, ram_q, cur;
   ldp_pkg::step_type     res;
   logic [ldp_pkg::MAX_COLUMNS-1:0] valid_ff, valid_in;
   logic [1:0]            q_count;
   logic [2:0]            fill;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff  <= 1'b0;
         wide_ff <= 1'b0;
         cols_ff <= 7'd1;
         lblk_ff <= '0;
      end else if (csr_valid) begin
         unique case (ldp_pkg::reg_index_type'(csr_index))
            ldp_pkg::REG_DECODE_MODE:    dec_ff  <= csr_wdata[0];
            ldp_pkg::REG_WIDE_SAMPLES:   wide_ff <= csr_wdata[0];
            ldp_pkg::REG_COLUMN_COUNT:   cols_ff <= csr_wdata[6:0];
            ldp_pkg::REG_LEARNED_BLOCKS: lblk_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign fill       = {1'b0, q_count} + {2'b00, s1_v_ff};
   assign req_tready = fill <= 3'(ldp_pkg::OQ_DEPTH - 1);
   assign accept     = req_tvalid && req_tready;

   ldp_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .first          (req_tuser),
      .column_count   (cols_ff),
      .learned_blocks (lblk_ff),
      .pos            (pos)
   );

   ldp_ram #(
      .WIDTH (ldp_pkg::ENTRY_W),
      .DEPTH (ldp_pkg::MAX_COLUMNS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_v_ff),
      .wr_addr (s1_pos_ff.col),
      .wr_data (res.st),
      .rd_addr (pos.col),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (s1_v_ff) begin
         valid_in[s1_pos_ff.col] = 1'b1;
      end
      if (accept && req_tuser) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         s1_v_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         s1_v_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff <= pos;
         s1_din_ff <= req_tdata;
         s1_vld_ff <= valid_ff[pos.col] && !req_tuser;
         s1_fwd_ff <= s1_v_ff && (s1_pos_ff.col == pos.col) && !req_tuser;
      end
      fwd_ff <= res.st;
   end

   always_comb begin
      if (s1_fwd_ff) begin
         cur = fwd_ff;
      end else if (s1_vld_ff) begin
         cur = ram_q;
      end else begin
         cur = '0;
      end
      res = ldp_pkg::ldp_step(cur, s1_din_ff, s1_pos_ff.row, s1_pos_ff.learned,
                              dec_ff, wide_ff);
   end

   ldp_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_v_ff),
      .push_data  (res.dout),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .count      (q_count)
   );

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s1_fwd_ff) |-> $past(s1_v_ff))
      else $error("forward without prior write");

   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> ($countones(valid_ff) == 0))
      else $error("valid bits not cleared on new buffer");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the learned delta predictive codec core. A short
// table of directed samples is followed by random phases with random codec
// direction and sample width, several column counts and learning lengths.
// Every result is checked against a table value or an in-bench model of the
// codec, while the sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit          first;
      logic [15:0] sample;
      bit          known;
      logic [15:0] result;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   logic [15:0] codec_prev_value [ldp_pkg::MAX_COLUMNS];
   logic [15:0] codec_prev_delta [ldp_pkg::MAX_COLUMNS];
   logic [31:0] codec_counter    [ldp_pkg::MAX_COLUMNS];
   logic [15:0] codec_grad_sum   [ldp_pkg::MAX_COLUMNS];
   int          codec_col;
   int          codec_row;
   logic [23:0] codec_blocks;
   bit          mode_decode;
   bit          mode_wide;
   logic [6:0]  mode_columns;
   logic [23:0] mode_learned;

   logic [15:0] expected_samples [$];
   int          mismatch_count;
   int          sent_count;
   int          checked_count;
   int          burst_left;
   bit          long_hold_request;
   logic [15:0] signal_level [ldp_pkg::MAX_COLUMNS];

   learned_delta_predictor_codec_core uut (.*);

   always #5 clock = ~clock;

   function automatic logic [15:0] code_sample(bit first, logic [15:0] din);
      int                 cols;
      int                 c;
      logic [15:0]        m, x, pv, pd, coef, pred, delta, val, err, g, low;
      logic signed [31:0] k, p, adj;
      logic signed [7:0]  adj8;
      bit                 learning;
      if (first) begin
         for (int i = 0; i < ldp_pkg::MAX_COLUMNS; i++) begin
            codec_prev_value[i] = '0;
            codec_prev_delta[i] = '0;
            codec_counter[i]    = '0;
            codec_grad_sum[i]   = '0;
         end
         codec_col    = 0;
         codec_row    = 0;
         codec_blocks = '0;
      end
      cols = (mode_columns == 0) ? 1 : int'(mode_columns);
      if (cols > ldp_pkg::MAX_COLUMNS) cols = ldp_pkg::MAX_COLUMNS;
      if (codec_col >= cols) codec_col = 0;
      c        = codec_col;
      m        = mode_wide ? 16'hffff : 16'h00ff;
      x        = din & m;
      pv       = codec_prev_value[c] & m;
      pd       = codec_prev_delta[c] & m;
      learning = codec_blocks < mode_learned;
      pred     = '0;
      if (learning) begin
         if (mode_wide) begin
            k    = $signed(codec_counter[c]) >>> 15;
            coef = {k[3:0], 12'h000};
            p    = $signed({{16{pd[15]}}, pd}) * $signed({{16{coef[15]}}, coef});
            pred = {p[29:16], 2'b00};
         end else begin
            k    = $signed({{16{codec_counter[c][15]}}, codec_counter[c][15:0]}) >>> 5;
            coef = {k[11:0], 4'h0};
            low  = {{8{pd[7]}}, pd[7:0]} * coef;
            pred = {8'h00, low[15:8]};
         end
      end
      if (mode_decode) begin
         err   = x;
         delta = (err + pred) & m;
         val   = (delta + pv) & m;
      end else begin
         val   = x;
         delta = (val - pv) & m;
         err   = (delta - pred) & m;
      end
      if (learning) begin
         if (codec_row % 2 == 1) begin
            if (err == 0) g = '0;
            else if (mode_wide ? err[15] : err[7]) g = 16'h0000 - pd;
            else g = pd;
            codec_grad_sum[c] = (codec_grad_sum[c] + g) & m;
         end
         if (codec_row == ldp_pkg::BLOCK_ROWS - 1) begin
            if (mode_wide) begin
               adj = $signed({{16{codec_grad_sum[c][15]}}, codec_grad_sum[c]})
                     >>> ldp_pkg::GRAD_SHIFT;
               codec_counter[c] = codec_counter[c] + adj;
            end else begin
               adj8 = $signed(codec_grad_sum[c][7:0]) >>> ldp_pkg::GRAD_SHIFT;
               codec_counter[c] = {16'h0000,
                                   codec_counter[c][15:0] + {{8{adj8[7]}}, adj8}};
            end
            codec_grad_sum[c] = '0;
         end
      end
      codec_prev_value[c] = val;
      codec_prev_delta[c] = delta;
      codec_col = c + 1;
      if (codec_col >= cols) begin
         codec_col = 0;
         if (codec_row >= ldp_pkg::BLOCK_ROWS - 1) begin
            codec_row = 0;
            if (learning) codec_blocks = codec_blocks + 24'd1;
         end else begin
            codec_row++;
         end
      end
      return mode_decode ? val : err;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s at %0t: got %h, want %h", what, $realtime, got, want);
      mismatch_count++;
   endtask

   task automatic write_register(ldp_pkg::reg_index_type idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (idx)
         ldp_pkg::REG_DECODE_MODE:    mode_decode  = value[0];
         ldp_pkg::REG_WIDE_SAMPLES:   mode_wide    = value[0];
         ldp_pkg::REG_COLUMN_COUNT:   mode_columns = value[6:0];
         ldp_pkg::REG_LEARNED_BLOCKS: mode_learned = value;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(bit dec, bit wide, logic [6:0] cols, logic [23:0] learned);
      wait_drained();
      write_register(ldp_pkg::REG_DECODE_MODE, {23'd0, dec});
      write_register(ldp_pkg::REG_WIDE_SAMPLES, {23'd0, wide});
      write_register(ldp_pkg::REG_COLUMN_COUNT, {17'd0, cols});
      write_register(ldp_pkg::REG_LEARNED_BLOCKS, learned);
      csr_valid <= 1'b0;
   endtask

   // Hold the request until accepted, then insert an occasional gap.
   task automatic send_sample(bit first, logic [15:0] sample, bit known, logic [15:0] result);
      int          gap;
      logic [15:0] want;
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = code_sample(first, sample);
      expected_samples.push_back(known ? result : want);
      sent_count++;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 16'h0000);
         end else begin
            logic [15:0] want;
            want = expected_samples.pop_front();
            checked_count++;
            if (rsp_tdata !== want) report_mismatch("sample_out", rsp_tdata, want);
         end
      end
   end

   initial begin
      int cycle_no;
      int stall_mode;
      int hold_left;
      cycle_no  = 0;
      hold_left = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no % 64 == 0) stall_mode = $urandom_range(0, 3);
         if (long_hold_request && hold_left == 0) begin
            hold_left         = 80;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            unique case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               2: rsp_tready <= (cycle_no % 3 != 0);
               default: rsp_tready <= (cycle_no % 8 < 2);
            endcase
         end
      end
   end

   initial begin
      #3ms;
      $display("timeout with %0d results pending", expected_samples.size());
      $display("testbench failed");
      $finish;
   end

   initial begin
      vector_type  directed [$];
      bit          dec, wide, first;
      logic [6:0]  cols;
      logic [23:0] learned;
      logic [15:0] sample;
      int          phase_items, span, settle;
      mismatch_count    = 0;
      sent_count        = 0;
      checked_count     = 0;
      burst_left        = 0;
      long_hold_request = 1'b0;
      mode_decode  = 1'b0;
      mode_wide    = 1'b0;
      mode_columns = 7'd1;
      mode_learned = '0;
      void'(code_sample(1'b1, 16'h0000));
      codec_col = 0;
      codec_row = 0;
      for (int i = 0; i < ldp_pkg::MAX_COLUMNS; i++) signal_level[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: narrow plain delta encode, one column.
      directed = '{
         '{1'b1, 16'h0000, 1'b1, 16'h0000},
         '{1'b0, 16'h00ff, 1'b1, 16'h00ff},
         '{1'b0, 16'h0000, 1'b1, 16'h0001},
         '{1'b0, 16'hff80, 1'b1, 16'h0080},
         '{1'b0, 16'h007f, 1'b1, 16'h00ff},
         '{1'b1, 16'h0042, 1'b1, 16'h0042},
         '{1'b0, 16'hffff, 1'b1, 16'h00bd},
         '{1'b0, 16'h0001, 1'b0, 16'h0000}
      };
      foreach (directed[i])
         send_sample(directed[i].first, directed[i].sample, directed[i].known,
                     directed[i].result);

      configure(1'b1, 1'b1, 7'd2, 24'hffffff);
      directed = '{
         '{1'b1, 16'h8000, 1'b0, 16'h0}, '{1'b0, 16'h7fff, 1'b0, 16'h0},
         '{1'b0, 16'hffff, 1'b0, 16'h0}, '{1'b0, 16'h0001, 1'b0, 16'h0},
         '{1'b0, 16'h8000, 1'b0, 16'h0}, '{1'b0, 16'h7fff, 1'b0, 16'h0}
      };
      foreach (directed[i]) send_sample(directed[i].first, directed[i].sample, 1'b0, 16'h0);
      configure(1'b0, 1'b1, 7'd0, 24'd1);
      for (int i = 0; i < 10; i++) send_sample(i == 0, 16'(i * 16'h1111), 1'b0, 16'h0);

      for (int ph = 0; ph < 12; ph++) begin
         dec   = $urandom_range(0, 1);
         wide  = $urandom_range(0, 1);
         case (ph % 6)
            0: cols = 7'd1;
            1: cols = 7'd64;
            2: cols = 7'd127;
            3: cols = 7'd0;
            default: cols = 7'($urandom_range(1, 4));
         endcase
         case (ph % 4)
            0: learned = 24'hffffff;
            1: learned = 24'd0;
            2: learned = 24'($urandom_range(1, 3));
            default: learned = 24'($urandom);
         endcase
         if (ph == 11) begin
            cols    = 7'd3;
            learned = 24'h800000;
         end
         configure(dec, wide, cols, learned);
         if (ph == 2) long_hold_request = 1'b1;
         phase_items = 70;
         settle      = 0;
         for (int n = 0; n < phase_items; n++) begin
            first = (n == 0 && ph % 5 != 4) || ($urandom_range(0, 99) == 0);
            if (dec) begin
               span   = $urandom_range(0, 3);
               sample = (span == 0) ? 16'($urandom) : 16'($signed(4'($urandom)));
            end else if ($urandom_range(0, 9) == 0) begin
               sample = 16'($urandom);
            end else begin
               settle = $urandom_range(0, ldp_pkg::MAX_COLUMNS - 1);
               signal_level[settle] = signal_level[settle] + 16'($urandom_range(0, 20)) - 16'd8;
               sample = signal_level[settle] ^ (16'($urandom) & 16'hff00 & {16{wide}});
            end
            send_sample(first, sample, 1'b0, 16'h0);
            if (ph == 5 && n == 35) wait_drained();
         end
      end

      req_tvalid <= 1'b0;
      for (int t = 0; t < 5000 && expected_samples.size() != 0; t++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_samples.size() != 0) begin
         $display("%0d results never arrived", expected_samples.size());
         mismatch_count++;
      end
      $display("%0d samples coded, %0d results checked over 15 register settings",
               sent_count, checked_count);
      $display("both directions and widths, column counts 0 to 127, learning on and off");
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ldp_pkg.sv
design/ldp_ram.sv
design/ldp_seq.sv
design/ldp_outq.sv
design/learned_delta_predictor_codec_core.sv
bench/testbench.sv
